// ----- design/thl_pkg.sv -----
// ----------------------------------------------------------------------------
// thl_pkg
// Shared types and constants for the toggle handshake byte link.
// ----------------------------------------------------------------------------
package thl_pkg;

   // command codes carried on the request channel
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_START = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // shift word contents after reset, before masking to the word width
   localparam logic [7:0] RESET_SHIFT = 8'd123;

   // line levels and the final acknowledge flag
   typedef struct packed {
      logic valid_level;
      logic toggle_level;
      logic bit_level;
      logic final_ack_wait;
   } line_state_type;

   // one result item
   typedef struct packed {
      logic       valid_line_out;
      logic       bit_line_out;
      logic       toggle_line_out;
      logic       byte_done;
      logic [7:0] byte_value;
      logic       busy_res;
   } result_type;

endpackage

// ----- design/thl_step.sv -----
// ----------------------------------------------------------------------------
// thl_step
// Next-state and result logic for one item of the byte link.
// ----------------------------------------------------------------------------
module thl_step #(
   parameter int WORD_BITS = 8
) (
   input  logic                         is_sender,
   input  thl_pkg::line_state_type      lines_cur,
   input  logic [$clog2(WORD_BITS+1)-1:0] bits_cur,
   input  logic [WORD_BITS-1:0]         shift_cur,
   input  thl_pkg::cmd_type             cmd,
   input  logic [7:0]                   data_byte,
   input  logic                         valid_line_in,
   input  logic                         toggle_line_in,
   input  logic                         bit_line_in,
   output thl_pkg::line_state_type      lines_nxt,
   output logic [$clog2(WORD_BITS+1)-1:0] bits_nxt,
   output logic [WORD_BITS-1:0]         shift_nxt,
   output thl_pkg::result_type          result
);

   localparam int CNT_W = $clog2(WORD_BITS + 1);
   localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(WORD_BITS);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   logic                 busy_cur;
   logic                 busy_nxt;
   logic                 done;
   logic [WORD_BITS-1:0] shifted;
   logic [WORD_BITS-1:0] rx_bit;
   logic [CNT_W-1:0]     bits_inc;

   assign busy_cur = (bits_cur < WORD_CNT) || lines_cur.final_ack_wait;
   assign shifted  = shift_cur >> 1;
   // data line is active low, so a low level is a one bit
   assign rx_bit   = WORD_BITS'(!bit_line_in) << bits_cur;
   assign bits_inc = bits_cur + ONE_CNT;

   // command decode and role behavior
   always_comb begin
      lines_nxt = lines_cur;
      bits_nxt  = bits_cur;
      shift_nxt = shift_cur;
      done      = 1'b0;
      unique case (cmd)
         thl_pkg::CMD_LOAD: begin
            if (!busy_cur) shift_nxt = WORD_BITS'(data_byte);
         end
         thl_pkg::CMD_START: begin
            if (!busy_cur) begin
               if (is_sender) begin
                  bits_nxt               = ONE_CNT;
                  lines_nxt.bit_level    = ~shift_cur[0];
                  lines_nxt.toggle_level = ~lines_cur.toggle_level;
               end else begin
                  lines_nxt.valid_level = ~lines_cur.valid_level;
               end
            end
         end
         thl_pkg::CMD_TICK: begin
            if (is_sender) begin
               // sender advances on each acknowledge flip
               if (valid_line_in != lines_cur.valid_level) begin
                  lines_nxt.valid_level = valid_line_in;
                  priority if (lines_cur.final_ack_wait) begin
                     lines_nxt.final_ack_wait = 1'b0;
                     done                     = 1'b1;
                  end else if (bits_cur >= WORD_CNT) begin
                     bits_nxt               = ONE_CNT;
                     lines_nxt.bit_level    = ~shift_cur[0];
                     lines_nxt.toggle_level = ~lines_cur.toggle_level;
                  end else begin
                     shift_nxt              = shifted;
                     lines_nxt.bit_level    = ~shifted[0];
                     lines_nxt.toggle_level = ~lines_cur.toggle_level;
                     bits_nxt               = bits_inc;
                     if (bits_inc >= WORD_CNT) lines_nxt.final_ack_wait = 1'b1;
                  end
               end
            end else begin
               // receiver samples the data line on each strobe flip
               if (toggle_line_in != lines_cur.toggle_level) begin
                  lines_nxt.toggle_level = toggle_line_in;
                  if (bits_cur >= WORD_CNT) begin
                     shift_nxt = WORD_BITS'(!bit_line_in);
                     bits_nxt  = ONE_CNT;
                  end else begin
                     shift_nxt = shift_cur | rx_bit;
                     bits_nxt  = bits_inc;
                     if (bits_inc >= WORD_CNT) done = 1'b1;
                  end
                  lines_nxt.valid_level = ~lines_cur.valid_level;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign busy_nxt = (bits_nxt < WORD_CNT) || lines_nxt.final_ack_wait;

   // result fields, lines not owned by the role stay released high
   always_comb begin
      result.valid_line_out  = is_sender ? 1'b1 : lines_nxt.valid_level;
      result.bit_line_out    = is_sender ? lines_nxt.bit_level : 1'b1;
      result.toggle_line_out = is_sender ? lines_nxt.toggle_level : 1'b1;
      result.byte_done       = done;
      result.byte_value      = 8'(shift_nxt);
      result.busy_res        = busy_nxt;
   end

endmodule

// ----- design/toggle_handshake_byte_link.sv -----
// ----------------------------------------------------------------------------
// toggle_handshake_byte_link
// One end of a three-wire, LSB-first toggle handshake serial link.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one item per transfer: a command (tick, load,
//   start) and the sampled levels of the partner's valid, toggle and data
//   lines. The rsp_ channel returns exactly one result per item: the line
//   levels to drive, a done flag, the low byte of the shift word and busy.
//   The csr_ channel writes the role bit (1 sender, 0 receiver); a write
//   aborts any transfer and clears the shift word. Write it only while idle.
//   An item is captured in the input register at its transfer edge and its
//   result is registered in the result register when the item advances; a
//   stalled output holds that off, and rsp_valid rises once it is registered.
//   Throughput: one item per cycle unless the output stalls; both registers
//   advance together, so it takes a new item while a finished result waits.
//   When rsp_stall is high with a result held, the input register holds its
//   item and req_stall rises; nothing is lost or repeated.
//   Reset (synchronous, active high): receiver role, all lines high, link
//   idle, shift word 123 masked to the word width, both registers empty.
// ----------------------------------------------------------------------------
module toggle_handshake_byte_link #(
   parameter int WORD_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_data_byte,
   input  logic       req_valid_line_in,
   input  logic       req_toggle_line_in,
   input  logic       req_bit_line_in,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_valid_line_out,
   output logic       rsp_bit_line_out,
   output logic       rsp_toggle_line_out,
   output logic       rsp_byte_done,
   output logic [7:0] rsp_byte_value,
   output logic       rsp_busy_res,
   // configuration channel
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_is_sender
);

   localparam int CNT_W = $clog2(WORD_BITS + 1);
   localparam logic [CNT_W-1:0] WORD_CNT = CNT_W'(WORD_BITS);

   // input register
   logic       in_valid_ff,  in_valid_in;
   logic [1:0] in_cmd_ff;
   logic [7:0] in_data_ff;
   logic       in_vin_ff, in_tin_ff, in_bin_ff;

   // link state
   logic                     is_sender_ff, is_sender_in;
   thl_pkg::line_state_type  lines_ff, lines_in, lines_step;
   logic [CNT_W-1:0]         bits_ff, bits_in, bits_step;
   logic [WORD_BITS-1:0]     shift_ff, shift_in, shift_step;

   // result register
   logic                 out_valid_ff, out_valid_in;
   thl_pkg::result_type  out_ff, out_in;

   logic req_xfer;
   logic advance;
   logic csr_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = !in_valid_ff;
   assign csr_xfer  = csr_valid && csr_ready;

   thl_step #(
      .WORD_BITS(WORD_BITS)
   ) u_step (
      .is_sender     (is_sender_ff),
      .lines_cur     (lines_ff),
      .bits_cur      (bits_ff),
      .shift_cur     (shift_ff),
      .cmd           (thl_pkg::cmd_type'(in_cmd_ff)),
      .data_byte     (in_data_ff),
      .valid_line_in (in_vin_ff),
      .toggle_line_in(in_tin_ff),
      .bit_line_in   (in_bin_ff),
      .lines_nxt     (lines_step),
      .bits_nxt      (bits_step),
      .shift_nxt     (shift_step),
      .result        (out_in)
   );

   // next values of the valid flags
   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // next state: a register write aborts the transfer, else the item updates it
   always_comb begin
      is_sender_in = is_sender_ff;
      lines_in     = lines_ff;
      bits_in      = bits_ff;
      shift_in     = shift_ff;
      priority if (csr_xfer) begin
         is_sender_in            = csr_is_sender;
         lines_in.final_ack_wait = 1'b0;
         bits_in                 = WORD_CNT;
         shift_in                = '0;
      end else if (advance) begin
         lines_in = lines_step;
         bits_in  = bits_step;
         shift_in = shift_step;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         is_sender_ff <= 1'b0;
         lines_ff     <= '{valid_level: 1'b1, toggle_level: 1'b1,
                           bit_level: 1'b1, final_ack_wait: 1'b0};
         bits_ff      <= WORD_CNT;
         shift_ff     <= WORD_BITS'(thl_pkg::RESET_SHIFT);
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         is_sender_ff <= is_sender_in;
         lines_ff     <= lines_in;
         bits_ff      <= bits_in;
         shift_ff     <= shift_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_cmd_ff  <= req_cmd;
         in_data_ff <= req_data_byte;
         in_vin_ff  <= req_valid_line_in;
         in_tin_ff  <= req_toggle_line_in;
         in_bin_ff  <= req_bit_line_in;
      end
      if (advance) out_ff <= out_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_valid_line_out  = out_ff.valid_line_out;
   assign rsp_bit_line_out    = out_ff.bit_line_out;
   assign rsp_toggle_line_out = out_ff.toggle_line_out;
   assign rsp_byte_done       = out_ff.byte_done;
   assign rsp_byte_value      = out_ff.byte_value;
   assign rsp_busy_res        = out_ff.busy_res;

`ifndef NO_ASSERTIONS
   // a register write leaves the link idle
   assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> (bits_ff == WORD_CNT && !lines_ff.final_ack_wait))
      else $error("link not idle after register write");

   // bit count never passes the word width
   assert property (@(posedge clock) disable iff (reset)
      bits_ff <= WORD_CNT)
      else $error("bit count out of range");

   // final acknowledge wait only follows the last bit
   assert property (@(posedge clock) disable iff (reset)
      lines_ff.final_ack_wait |-> bits_ff == WORD_CNT)
      else $error("final acknowledge wait with bits pending");

   // a held result with a stalled output blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall && in_valid_ff) |-> req_stall)
      else $error("request taken while result stalled");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the toggle handshake byte link.
// Plays the link partner in both roles, predicts every result item in step
// with the accepted requests and compares the result channel field by field.
// Role changes are written over the csr channel only while the link is drained.
// ----------------------------------------------------------------------------
module tb;

   localparam int WORD_BITS   = 8;
   localparam int STUCK_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;

   // one request as the partner presents it
   typedef struct packed {
      thl_pkg::cmd_type cmd;
      logic [7:0]       data;
      logic             vin;
      logic             tin;
      logic             bin;
   } link_req_type;

   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic       req_stall;
   logic [1:0] req_cmd            = thl_pkg::CMD_TICK;
   logic [7:0] req_data_byte      = 8'd0;
   logic       req_valid_line_in  = 1'b1;
   logic       req_toggle_line_in = 1'b1;
   logic       req_bit_line_in    = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall          = 1'b0;
   logic       rsp_valid_line_out;
   logic       rsp_bit_line_out;
   logic       rsp_toggle_line_out;
   logic       rsp_byte_done;
   logic [7:0] rsp_byte_value;
   logic       rsp_busy_res;
   logic       csr_valid          = 1'b0;
   logic       csr_ready;
   logic       csr_is_sender      = 1'b0;

   // predicted link state
   logic       role_sender;
   logic       lvl_valid;
   logic       lvl_toggle;
   logic       lvl_bit;
   int         bits_moved;
   logic       ack_pending;
   logic [7:0] shift_word;

   // partner line levels as the request generator sees them
   logic       gen_sender;
   logic       gen_valid;
   logic       gen_toggle;

   link_req_type        link_cmds_q[$];
   thl_pkg::result_type link_results_q[$];
   link_req_type        cur_item;
   int         n_queued    = 0;
   int         n_checked   = 0;
   int         errors      = 0;
   int         stuck_cycles = 0;

   // sender burst shaping
   int         burst_left = 0;
   int         gap_left   = 0;

   // receiver stall pattern
   int         rx_cycle   = 0;
   int         hold_left  = 0;
   int         seg_left   = 0;
   int         stall_mode = 0;

   toggle_handshake_byte_link i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_data_byte       (req_data_byte),
      .req_valid_line_in   (req_valid_line_in),
      .req_toggle_line_in  (req_toggle_line_in),
      .req_bit_line_in     (req_bit_line_in),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_valid_line_out  (rsp_valid_line_out),
      .rsp_bit_line_out    (rsp_bit_line_out),
      .rsp_toggle_line_out (rsp_toggle_line_out),
      .rsp_byte_done       (rsp_byte_done),
      .rsp_byte_value      (rsp_byte_value),
      .rsp_busy_res        (rsp_busy_res),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_is_sender       (csr_is_sender)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic link_busy();
      return (bits_moved < WORD_BITS) || ack_pending;
   endfunction

   // put the low shift bit on the data line (active low) and flip the strobe
   function automatic void post_next_bit();
      lvl_bit    = ~shift_word[0];
      lvl_toggle = ~lvl_toggle;
   endfunction

   // advance the predicted link by one request and return its result
   function automatic thl_pkg::result_type step_link(input link_req_type it);
      thl_pkg::result_type r;
      logic                got;
      logic                done_now;
      done_now = 1'b0;
      case (it.cmd)
         thl_pkg::CMD_LOAD: begin
            if (!link_busy()) shift_word = it.data;
         end
         thl_pkg::CMD_START: begin
            if (!link_busy()) begin
               if (role_sender) begin
                  bits_moved = 1;
                  post_next_bit();
               end else begin
                  lvl_valid = ~lvl_valid;
               end
            end
         end
         thl_pkg::CMD_TICK: begin
            if (role_sender) begin
               // sender advances on each acknowledge flip
               if (it.vin != lvl_valid) begin
                  lvl_valid = it.vin;
                  if (ack_pending) begin
                     ack_pending = 1'b0;
                     done_now    = 1'b1;
                  end else if (bits_moved >= WORD_BITS) begin
                     bits_moved = 1;
                     post_next_bit();
                  end else begin
                     shift_word = shift_word >> 1;
                     post_next_bit();
                     bits_moved++;
                     if (bits_moved >= WORD_BITS) ack_pending = 1'b1;
                  end
               end
            end else if (it.tin != lvl_toggle) begin
               // receiver samples the data line on each strobe flip
               got        = ~it.bin;
               lvl_toggle = it.tin;
               if (bits_moved >= WORD_BITS) begin
                  shift_word = {7'd0, got};
                  bits_moved = 1;
               end else begin
                  shift_word = shift_word | (8'(got) << bits_moved);
                  bits_moved++;
                  if (bits_moved >= WORD_BITS) done_now = 1'b1;
               end
               lvl_valid = ~lvl_valid;
            end
         end
         default: ;
      endcase
      r.valid_line_out  = role_sender ? 1'b1 : lvl_valid;
      r.bit_line_out    = role_sender ? lvl_bit : 1'b1;
      r.toggle_line_out = role_sender ? lvl_toggle : 1'b1;
      r.byte_done       = done_now;
      r.byte_value      = shift_word;
      r.busy_res        = link_busy();
      return r;
   endfunction

   task automatic push_cmd(input thl_pkg::cmd_type c, input logic [7:0] d,
                           input logic v, input logic t, input logic b);
      link_req_type it;
      it = '{cmd: c, data: d, vin: v, tin: t, bin: b};
      // after any tick the link holds the partner levels it just saw
      if (c == thl_pkg::CMD_TICK) begin
         gen_valid  = v;
         gen_toggle = t;
      end
      link_cmds_q.push_back(it);
      n_queued++;
   endtask

   // tick that flips the partner line the current role listens to
   task automatic push_flip(input logic b);
      if (gen_sender)
         push_cmd(thl_pkg::CMD_TICK, 8'($urandom), ~gen_valid, 1'($urandom), b);
      else
         push_cmd(thl_pkg::CMD_TICK, 8'($urandom), 1'($urandom), ~gen_toggle, b);
   endtask

   // something between bits: mostly quiet ticks, sometimes other commands
   task automatic push_filler();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 6)
         push_cmd(thl_pkg::CMD_LOAD, 8'($urandom),
                  1'($urandom), 1'($urandom), 1'($urandom));
      else if (pick == 7)
         push_cmd(thl_pkg::CMD_START, 8'($urandom),
                  1'($urandom), 1'($urandom), 1'($urandom));
      else if (pick == 8)
         push_cmd(thl_pkg::CMD_NONE, 8'($urandom),
                  1'($urandom), 1'($urandom), 1'($urandom));
      else if (gen_sender)
         push_cmd(thl_pkg::CMD_TICK, 8'($urandom), gen_valid, 1'($urandom), 1'($urandom));
      else
         push_cmd(thl_pkg::CMD_TICK, 8'($urandom), 1'($urandom), gen_toggle, 1'($urandom));
   endtask

   task automatic wait_drained();
      while (n_checked != n_queued) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_role(input logic role);
      wait_drained();
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_is_sender <= role;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      // role write aborts any transfer and clears the shift word
      role_sender = role;
      bits_moved  = WORD_BITS;
      ack_pending = 1'b0;
      shift_word  = 8'd0;
      gen_sender  = role;
      gen_valid   = lvl_valid;
      gen_toggle  = lvl_toggle;
   endtask

   // mostly whole bytes with random content, some cut short, some noise
   task automatic random_phase(input int n_items);
      int stop_at;
      int pick;
      int nbits;
      stop_at = n_queued + n_items;
      while (n_queued < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            nbits = (pick == 7) ? $urandom_range(1, WORD_BITS - 1) : WORD_BITS;
            if (gen_sender) begin
               push_cmd(thl_pkg::CMD_LOAD, 8'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom));
               push_cmd(thl_pkg::CMD_START, 8'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom));
            end else if ($urandom_range(0, 1) == 1) begin
               push_cmd(thl_pkg::CMD_START, 8'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom));
            end
            for (int k = 0; k < nbits; k++) begin
               while ($urandom_range(0, 2) == 0) push_filler();
               push_flip(1'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 4))
               push_cmd(thl_pkg::cmd_type'($urandom_range(0, 3)), 8'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom));
         end
      end
   endtask

   // request driver: bursts with random gaps, payload held while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) link_results_q.push_back(step_link(cur_item));
         if (req_valid && req_stall) begin
            // hold the stalled transfer
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (link_cmds_q.size() > 0) begin
            cur_item = link_cmds_q.pop_front();
            req_cmd            <= cur_item.cmd;
            req_data_byte      <= cur_item.data;
            req_valid_line_in  <= cur_item.vin;
            req_toggle_line_in <= cur_item.tin;
            req_bit_line_in    <= cur_item.bin;
            req_valid          <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall pattern, with a long hold-off now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rx_cycle % 2500 == 400) begin
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left   = $urandom_range(8, 60);
               stall_mode = $urandom_range(0, 3);
            end
            seg_left--;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= rx_cycle[0];
            endcase
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      thl_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (link_results_q.size() == 0) begin
            $display("%0t: result transfer with nothing expected, actual byte %0h",
                     $time, rsp_byte_value);
            errors++;
         end else begin
            want = link_results_q.pop_front();
            check_field("valid_line_out", want.valid_line_out, rsp_valid_line_out);
            check_field("bit_line_out", want.bit_line_out, rsp_bit_line_out);
            check_field("toggle_line_out", want.toggle_line_out, rsp_toggle_line_out);
            check_field("byte_done", want.byte_done, rsp_byte_done);
            check_field("byte_value", want.byte_value, rsp_byte_value);
            check_field("busy_res", want.busy_res, rsp_busy_res);
            n_checked++;
         end
      end
   end

   // count cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("tb: FAIL");
      $finish;
   end

   // stimulus
   initial begin
      logic role;
      role_sender = 1'b0;
      lvl_valid   = 1'b1;
      lvl_toggle  = 1'b1;
      lvl_bit     = 1'b1;
      bits_moved  = WORD_BITS;
      ack_pending = 1'b0;
      shift_word  = thl_pkg::RESET_SHIFT;
      gen_sender  = 1'b0;
      gen_valid   = 1'b1;
      gen_toggle  = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // receiver after reset: unused command, loads, call, one full byte
      push_cmd(thl_pkg::CMD_NONE, 8'hFF, 1'b0, 1'b0, 1'b0);
      push_cmd(thl_pkg::CMD_LOAD, 8'h00, gen_valid, gen_toggle, 1'b1);
      push_cmd(thl_pkg::CMD_LOAD, 8'hFF, gen_valid, gen_toggle, 1'b1);
      push_cmd(thl_pkg::CMD_START, 8'h00, gen_valid, gen_toggle, 1'b1);
      push_flip(1'b0);
      // load and start while busy are ignored and do not sample the pins
      push_cmd(thl_pkg::CMD_LOAD, 8'hAA, gen_valid, ~gen_toggle, 1'b0);
      push_cmd(thl_pkg::CMD_START, 8'h55, ~gen_valid, ~gen_toggle, 1'b0);
      for (int k = 0; k < WORD_BITS - 1; k++) push_flip(1'(k));

      // sender: load, start, ignored load, then every acknowledge
      write_role(1'b1);
      push_cmd(thl_pkg::CMD_LOAD, 8'h81, gen_valid, gen_toggle, 1'b0);
      push_cmd(thl_pkg::CMD_START, 8'h00, ~gen_valid, ~gen_toggle, 1'b1);
      push_cmd(thl_pkg::CMD_LOAD, 8'h7E, gen_valid, gen_toggle, 1'b0);
      repeat (WORD_BITS) push_flip(1'($urandom));

      for (int p = 0; p < 8; p++) begin
         role = (p < 4) ? (p == 1 || p == 2) : 1'($urandom);
         write_role(role);
         random_phase(115);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0 && link_results_q.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/thl_pkg.sv
design/thl_step.sv
design/toggle_handshake_byte_link.sv
sim/tb.sv
